// File: rtl/tse_pkg.sv
// shared types and constants of the topological sort engine
// no dependencies
package tse_pkg;

  localparam int unsigned VSLOTS = 32;
  localparam int unsigned VX_W   = 5;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned DEG_W  = 10;

  typedef enum logic [1:0] {
    ACT_SET_DEG = 2'd0,
    ACT_ADD_ARC = 2'd1,
    ACT_START   = 2'd2,
    ACT_CLEAR   = 2'd3
  } tse_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_ARC_RD,
    ST_ARC_UPD,
    ST_SUM
  } tse_state_e;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic pop_emit;
    logic arc_read;
    logic arc_update;
    logic sum_emit;
  } tse_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic stack_empty;
    logic count_full;
    logic has_arcs;
    logic arc_last;
    logic out_free;
  } tse_status_t;

endpackage

// File: rtl/tse_if.sv
// handshake channels of the topological sort engine
// input item channel and result item channel, no dependencies
interface tse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] vertex;
  logic [7:0] indegree_value;
  logic [4:0] arc_target;

  modport source(output valid, action, vertex, indegree_value, arc_target, input ready);
  modport sink(input valid, action, vertex, indegree_value, arc_target, output ready);
endinterface

interface tse_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] vertex_out;
  logic [5:0] order_count;
  logic       acyclic;
  logic       arc_dropped;
  logic       last;

  modport source(output valid, kind, vertex_out, order_count, acyclic, arc_dropped, last,
                 input ready);
  modport sink(input valid, kind, vertex_out, order_count, acyclic, arc_dropped, last,
               output ready);
endinterface

// File: rtl/topological_sort_engine_unit.sv
// top level of the topological sort engine: register port, controller, datapath
// depends on tse_pkg, tse_if, tse_ctrl and tse_dp
//
// Kahn topological sort with a LIFO work stack. In-degree, add-arc and clear
// items are done in their transfer cycle. A start item takes the transfer,
// a scan of each vertex for zero in-degrees plus a step to leave the scan,
// a step per popped vertex plus one to find the stack empty or the count
// full, and per arc walked an address step, whose registered read of the
// single-port arc memories is followed by the degree update, then the summary;
// result back-pressure can stall the pops and the summary. One item is worked
// on at a time; no clearing pass.
module topological_sort_engine_unit #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_ARCS     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tse_in_if.sink      in_i,
  tse_out_if.source   out_o
);
  import tse_pkg::*;

  localparam int unsigned VLIM = (MAX_VERTICES < VSLOTS) ? MAX_VERTICES : VSLOTS;

  logic [5:0]  vc_q;
  logic [5:0]  nv;
  tse_cmd_t    cmd;
  tse_status_t status;

  assign pready = 1'b1;
  assign prdata = {26'd0, vc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      vc_q <= pwdata[5:0];
    end
  end

  assign nv = (vc_q > 6'(VLIM)) ? 6'(VLIM) : vc_q;

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_action_i(in_i.action),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tse_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_ARCS    (MAX_ARCS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .nv_i            (nv),
    .action_i        (in_i.action),
    .vertex_i        (in_i.vertex),
    .indegree_value_i(in_i.indegree_value),
    .arc_target_i    (in_i.arc_target),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .kind_o          (out_o.kind),
    .vertex_out_o    (out_o.vertex_out),
    .order_count_o   (out_o.order_count),
    .acyclic_o       (out_o.acyclic),
    .arc_dropped_o   (out_o.arc_dropped),
    .last_o          (out_o.last)
  );

endmodule

// File: rtl/tse_ctrl.sv
// sequencing state machine of the topological sort engine
// depends on tse_pkg
module tse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_action_i,
  output logic                 in_ready_o,
  input  tse_pkg::tse_status_t status_i,
  output tse_pkg::tse_cmd_t    cmd_o
);
  import tse_pkg::*;

  tse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (tse_action_e'(in_action_i) == ACT_START) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (status_i.stack_empty || status_i.count_full) begin
          state_d = ST_SUM;
        end else if (status_i.out_free) begin
          cmd_o.pop_emit = 1'b1;
          state_d = status_i.has_arcs ? ST_ARC_RD : ST_POP;
        end
      end
      ST_ARC_RD: begin
        cmd_o.arc_read = 1'b1;
        state_d = ST_ARC_UPD;
      end
      ST_ARC_UPD: begin
        cmd_o.arc_update = 1'b1;
        state_d = status_i.arc_last ? ST_POP : ST_ARC_RD;
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.sum_emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/tse_dp.sv
// datapath of the topological sort engine: degree store, arc lists,
// work stack, counters and result register; depends on tse_pkg
module tse_dp #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_ARCS     = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tse_pkg::tse_cmd_t    cmd_i,
  output tse_pkg::tse_status_t status_o,
  input  logic [5:0]           nv_i,
  input  logic [1:0]           action_i,
  input  logic [4:0]           vertex_i,
  input  logic [7:0]           indegree_value_i,
  input  logic [4:0]           arc_target_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 kind_o,
  output logic [4:0]           vertex_out_o,
  output logic [5:0]           order_count_o,
  output logic                 acyclic_o,
  output logic                 arc_dropped_o,
  output logic                 last_o
);
  import tse_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ARCS + 1);
  localparam int unsigned IW = $clog2(MAX_ARCS);

  // degree store and per-vertex list pointers
  logic [DEG_W-1:0] deg_q [VSLOTS];
  logic [VSLOTS-1:0] head_vld_q, head_vld_d;
  logic [IW-1:0]     head_q [VSLOTS];
  logic [IW-1:0]     tail_q [VSLOTS];

  // arc memories
  logic [VX_W-1:0] dest_mem [MAX_ARCS];
  logic [IW-1:0]   link_mem [MAX_ARCS];
  logic [VX_W-1:0] dest_rd_q;
  logic [IW-1:0]   link_rd_q;

  logic [AW-1:0]    used_q, used_d;
  logic             drop_q, drop_d;
  logic [VX_W-1:0]  stack_q [VSLOTS];
  logic [CNT_W-1:0] level_q, level_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic [IW-1:0]    arc_ptr_q, arc_ptr_d;
  logic [IW-1:0]    arc_end_q, arc_end_d;

  logic             out_valid_q, out_valid_d;
  logic             kind_q, acyclic_q, last_q, drop_out_q;
  logic [VX_W-1:0]  vx_out_q;
  logic [CNT_W-1:0] cnt_out_q;

  logic [CNT_W-1:0] lvl_m1;
  logic [VX_W-1:0]  top_vx;
  logic [VX_W-1:0]  deg_addr;
  logic [DEG_W-1:0] deg_rd, deg_dec;
  logic             deg_we;
  logic [VX_W-1:0]  deg_wa;
  logic [DEG_W-1:0] deg_wd;
  logic             push_en;
  logic [VX_W-1:0]  push_vx;
  logic             arc_ok, load_arc, load_deg, tgt_live;
  logic             out_free;
  tse_action_e      act;

  assign act      = tse_action_e'(action_i);
  assign lvl_m1   = level_q - CNT_W'(1);
  assign top_vx   = stack_q[lvl_m1[VX_W-1:0]];
  assign deg_addr = cmd_i.arc_update ? dest_rd_q : scan_idx_q[VX_W-1:0];
  assign deg_rd   = deg_q[deg_addr];
  assign deg_dec  = deg_rd - DEG_W'(1);
  assign tgt_live = {1'b0, dest_rd_q} < nv_i;
  assign out_free = !out_valid_q || out_ready_i;

  assign arc_ok   = ({1'b0, vertex_i} < nv_i) && ({1'b0, arc_target_i} < nv_i)
                    && (used_q < AW'(MAX_ARCS));
  assign load_arc = cmd_i.load && (act == ACT_ADD_ARC) && arc_ok;
  assign load_deg = cmd_i.load && (act == ACT_SET_DEG)
                    && ({2'b00, vertex_i} < 7'(MAX_VERTICES));

  always_comb begin
    deg_we  = 1'b0;
    deg_wa  = vertex_i;
    deg_wd  = {2'b00, indegree_value_i};
    push_en = 1'b0;
    push_vx = scan_idx_q[VX_W-1:0];
    if (load_deg) begin
      deg_we = 1'b1;
    end
    if (cmd_i.scan_step && (deg_rd == '0)) begin
      push_en = 1'b1;
    end
    if (cmd_i.arc_update && tgt_live) begin
      deg_we = 1'b1;
      deg_wa = dest_rd_q;
      deg_wd = deg_dec;
      push_vx = dest_rd_q;
      push_en = (deg_dec == '0);
    end
  end

  always_comb begin
    head_vld_d = head_vld_q;
    used_d     = used_q;
    drop_d     = drop_q;
    level_d    = level_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    arc_ptr_d  = arc_ptr_q;
    arc_end_d  = arc_end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      unique case (act)
        ACT_ADD_ARC: begin
          if (arc_ok) begin
            head_vld_d[vertex_i] = 1'b1;
            used_d = used_q + AW'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
        ACT_CLEAR: begin
          head_vld_d = '0;
          used_d     = '0;
          drop_d     = 1'b0;
        end
        ACT_START: begin
          scan_idx_d = '0;
          level_d    = '0;
          count_d    = '0;
        end
        ACT_SET_DEG: ;
        default: ;
      endcase
    end
    if (cmd_i.scan_step) scan_idx_d = scan_idx_q + CNT_W'(1);
    if (push_en && !level_q[CNT_W-1]) level_d = level_q + CNT_W'(1);
    if (cmd_i.pop_emit) begin
      level_d     = lvl_m1;
      count_d     = count_q + CNT_W'(1);
      arc_ptr_d   = head_q[top_vx];
      arc_end_d   = tail_q[top_vx];
      out_valid_d = 1'b1;
    end
    if (cmd_i.arc_update) arc_ptr_d = link_rd_q;
    if (cmd_i.sum_emit) begin
      level_d     = '0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VSLOTS; i++) deg_q[i] <= '0;
      head_vld_q  <= '0;
      used_q      <= '0;
      drop_q      <= 1'b0;
      level_q     <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      arc_ptr_q   <= '0;
      arc_end_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (deg_we) deg_q[deg_wa] <= deg_wd;
      head_vld_q  <= head_vld_d;
      used_q      <= used_d;
      drop_q      <= drop_d;
      level_q     <= level_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      arc_ptr_q   <= arc_ptr_d;
      arc_end_q   <= arc_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (load_arc) begin
      if (!head_vld_q[vertex_i]) head_q[vertex_i] <= used_q[IW-1:0];
      tail_q[vertex_i] <= used_q[IW-1:0];
    end
    if (push_en && !level_q[CNT_W-1]) stack_q[level_q[VX_W-1:0]] <= push_vx;
    if (cmd_i.pop_emit) begin
      kind_q     <= 1'b0;
      vx_out_q   <= top_vx;
      cnt_out_q  <= count_q + CNT_W'(1);
      acyclic_q  <= 1'b0;
      drop_out_q <= drop_q;
      last_q     <= 1'b0;
    end else if (cmd_i.sum_emit) begin
      kind_q     <= 1'b1;
      vx_out_q   <= '0;
      cnt_out_q  <= count_q;
      acyclic_q  <= (count_q == nv_i);
      drop_out_q <= drop_q;
      last_q     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_arc) begin
      dest_mem[used_q[IW-1:0]] <= arc_target_i;
      if (head_vld_q[vertex_i]) link_mem[tail_q[vertex_i]] <= used_q[IW-1:0];
    end
    if (cmd_i.arc_read) begin
      dest_rd_q <= dest_mem[arc_ptr_q];
      link_rd_q <= link_mem[arc_ptr_q];
    end
  end

  assign status_o.scan_more   = scan_idx_q < nv_i;
  assign status_o.stack_empty = (level_q == '0);
  assign status_o.count_full  = (count_q == CNT_W'(VSLOTS));
  assign status_o.has_arcs    = head_vld_q[top_vx];
  assign status_o.arc_last    = (arc_ptr_q == arc_end_q);
  assign status_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign vertex_out_o  = vx_out_q;
  assign order_count_o = cnt_out_q;
  assign acyclic_o     = acyclic_q;
  assign arc_dropped_o = drop_out_q;
  assign last_o        = last_q;

endmodule
